@@ rtl/core/imu_fdb_pkg.sv @@
package imu_fdb_pkg;

  localparam int unsigned MaxImusDefault = 16;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;
  localparam int unsigned CountW   = 5;
  localparam int unsigned BpiW     = 7;
  localparam int unsigned GainW    = 24;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned RawW     = 16;
  localparam int unsigned AccW     = 19;
  localparam int unsigned RateW    = 29;
  localparam int unsigned IdxW     = 4;
  localparam int unsigned ProdW    = RawW + GainW + 1;
  localparam int unsigned ScaleSh  = 8;
  localparam int unsigned PosW     = 6;
  localparam int unsigned SmpW     = 3;
  localparam int unsigned AxesPerSensor = 3;

  localparam logic [CfgIdxW-1:0] CfgImuCount   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgBytesPerImu = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgAccelGain  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgGyroGain   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgBiasCapture = 3'd4;

  localparam logic [CountW-1:0] ImuCountRst    = 5'd1;
  localparam logic [BpiW-1:0]   BpiRst         = 7'd13;
  localparam logic [GainW-1:0]  AccelGainRst   = 24'd2048;
  localparam logic [GainW-1:0]  GyroGainRst    = 24'd1024031;

  localparam logic [BpiW-1:0]   BpiMin         = 7'd13;
  localparam logic [BpiW-1:0]   BpiMax         = 7'd64;
  localparam logic [PosW-1:0]   PosFirstData   = 6'd1;
  localparam logic [PosW-1:0]   PosFirstSample = 6'd2;
  localparam logic [PosW-1:0]   PosLastData    = 6'd12;

  localparam logic [SmpW-1:0]   SmpAccelX = 3'd0;
  localparam logic [SmpW-1:0]   SmpAccelY = 3'd1;
  localparam logic [SmpW-1:0]   SmpAccelZ = 3'd2;
  localparam logic [SmpW-1:0]   SmpGyroX  = 3'd3;
  localparam logic [SmpW-1:0]   SmpGyroY  = 3'd4;
  localparam logic [SmpW-1:0]   SmpGyroZ  = 3'd5;

  localparam logic signed [RateW-1:0] AccMax  = {{(RateW-AccW+1){1'b0}}, {(AccW-1){1'b1}}};
  localparam logic signed [RateW-1:0] AccMin  = {{(RateW-AccW+1){1'b1}}, {(AccW-1){1'b0}}};
  localparam logic signed [RateW-1:0] RateMax = {1'b0, {(RateW-1){1'b1}}};
  localparam logic signed [RateW-1:0] RateMin = {1'b1, {(RateW-1){1'b0}}};

  typedef struct packed {
    logic [SmpW-1:0] smp;
    logic            emit;
    logic            last;
    logic [IdxW-1:0] idx;
  } smp_tag_t;

endpackage

@@ rtl/core/imu_fdb_ram.sv @@
module imu_fdb_ram #(
  parameter int unsigned Width = 29,
  parameter int unsigned Depth = 48
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/imu_fdb_framer.sv @@
module imu_fdb_framer #(
  parameter int unsigned MaxImus = imu_fdb_pkg::MaxImusDefault,
  parameter int unsigned AddrW   = $clog2(MaxImus * imu_fdb_pkg::AxesPerSensor)
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 adv_i,
  input  logic                                 accept_i,
  input  logic [imu_fdb_pkg::ByteW-1:0]        rx_byte_i,
  input  logic                                 frame_start_i,
  input  logic [imu_fdb_pkg::CountW-1:0]       imu_count_i,
  input  logic [imu_fdb_pkg::BpiW-1:0]         bytes_per_imu_i,
  output logic                                 s1_valid_o,
  output logic signed [imu_fdb_pkg::RawW-1:0]  s1_raw_o,
  output imu_fdb_pkg::smp_tag_t                s1_tag_o,
  output logic [AddrW-1:0]                     s1_addr_o
);

  localparam int unsigned BlkW = $clog2(MaxImus + 1);

  logic [imu_fdb_pkg::PosW-1:0]  pos_q, pos_d, pos;
  logic [BlkW-1:0]               blk_q, blk_d, blk;
  logic [imu_fdb_pkg::ByteW-1:0] hi_q, hi_d;
  logic [BlkW-1:0]               cnt;
  logic [imu_fdb_pkg::BpiW-1:0]  bpi;
  logic [imu_fdb_pkg::BpiW-1:0]  pos_nx;
  logic [imu_fdb_pkg::PosW-1:0]  pos_m;
  logic [imu_fdb_pkg::SmpW-1:0]  smp;
  logic [1:0]                    axis;
  logic                          active;
  logic                          is_hi;
  logic                          is_smp;
  logic                          s1_valid_q;
  logic signed [imu_fdb_pkg::RawW-1:0] raw_q;
  imu_fdb_pkg::smp_tag_t         tag_q, tag_d;
  logic [AddrW-1:0]              addr_q, addr_d;

  always_comb begin
    if (imu_count_i == '0) begin
      cnt = BlkW'(1);
    end else if (32'(imu_count_i) > MaxImus) begin
      cnt = BlkW'(MaxImus);
    end else begin
      cnt = BlkW'(imu_count_i);
    end
    if (bytes_per_imu_i < imu_fdb_pkg::BpiMin) begin
      bpi = imu_fdb_pkg::BpiMin;
    end else if (bytes_per_imu_i > imu_fdb_pkg::BpiMax) begin
      bpi = imu_fdb_pkg::BpiMax;
    end else begin
      bpi = bytes_per_imu_i;
    end
  end

  always_comb begin
    pos    = frame_start_i ? '0 : pos_q;
    blk    = frame_start_i ? '0 : blk_q;
    active = (blk < cnt);
    pos_nx = {1'b0, pos} + 7'd1;
    is_hi  = (pos >= imu_fdb_pkg::PosFirstData) && (pos <= imu_fdb_pkg::PosLastData) && pos[0];
    is_smp = (pos >= imu_fdb_pkg::PosFirstSample) && (pos <= imu_fdb_pkg::PosLastData)
             && !pos[0];
    pos_m  = pos - imu_fdb_pkg::PosFirstSample;
    smp    = pos_m[imu_fdb_pkg::SmpW:1];
    axis   = 2'(smp - imu_fdb_pkg::SmpGyroX);

    tag_d.smp  = smp;
    tag_d.emit = (pos == imu_fdb_pkg::PosLastData);
    tag_d.last = ((32'(blk) + 32'd1) == 32'(cnt));
    tag_d.idx  = imu_fdb_pkg::IdxW'(blk);
    addr_d     = AddrW'(32'(blk) * imu_fdb_pkg::AxesPerSensor + 32'(axis));

    pos_d = pos_q;
    blk_d = blk_q;
    hi_d  = hi_q;
    if (accept_i) begin
      pos_d = pos;
      blk_d = blk;
      if (active) begin
        if (is_hi) begin
          hi_d = rx_byte_i;
        end
        if (pos_nx >= bpi) begin
          pos_d = '0;
          blk_d = blk + BlkW'(1);
        end else begin
          pos_d = pos_nx[imu_fdb_pkg::PosW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      blk_q      <= '0;
      hi_q       <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      blk_q <= blk_d;
      hi_q  <= hi_d;
      if (adv_i) begin
        s1_valid_q <= accept_i && active && is_smp;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      raw_q  <= $signed({hi_q, rx_byte_i});
      tag_q  <= tag_d;
      addr_q <= addr_d;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_raw_o   = raw_q;
  assign s1_tag_o   = tag_q;
  assign s1_addr_o  = addr_q;

endmodule

@@ rtl/core/imu_fdb_scale.sv @@
module imu_fdb_scale #(
  parameter int unsigned AddrW = 6
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 adv_i,
  input  logic                                 s1_valid_i,
  input  logic signed [imu_fdb_pkg::RawW-1:0]  s1_raw_i,
  input  imu_fdb_pkg::smp_tag_t                s1_tag_i,
  input  logic [AddrW-1:0]                     s1_addr_i,
  input  logic [imu_fdb_pkg::GainW-1:0]        accel_gain_i,
  input  logic [imu_fdb_pkg::GainW-1:0]        gyro_gain_i,
  input  logic signed [imu_fdb_pkg::RateW-1:0] bias_i,
  output logic                                 s3_valid_o,
  output logic signed [imu_fdb_pkg::RateW-1:0] s3_scaled_o,
  output logic signed [imu_fdb_pkg::RateW-1:0] s3_bias_o,
  output imu_fdb_pkg::smp_tag_t                s3_tag_o,
  output logic [AddrW-1:0]                     s3_addr_o
);

  localparam int unsigned ShW = imu_fdb_pkg::ProdW - imu_fdb_pkg::ScaleSh;

  logic [imu_fdb_pkg::GainW-1:0]        gain;
  logic signed [imu_fdb_pkg::ProdW-1:0] prod_d, prod_q;
  logic                                 s2_valid_q, s3_valid_q;
  imu_fdb_pkg::smp_tag_t                s2_tag_q, s3_tag_q;
  logic [AddrW-1:0]                     s2_addr_q, s3_addr_q;
  logic signed [ShW-1:0]                sh;
  logic                                 acc_ovf, rate_ovf;
  logic signed [imu_fdb_pkg::RateW-1:0] scaled_d, scaled_q, bias_q;

  assign gain   = (s1_tag_i.smp < imu_fdb_pkg::SmpGyroX) ? accel_gain_i : gyro_gain_i;
  assign prod_d = s1_raw_i * $signed({1'b0, gain});

  always_comb begin
    sh       = $signed(prod_q[imu_fdb_pkg::ProdW-1:imu_fdb_pkg::ScaleSh]);
    acc_ovf  = sh[ShW-1:imu_fdb_pkg::AccW-1] != {(ShW-imu_fdb_pkg::AccW+1){sh[imu_fdb_pkg::AccW-1]}};
    rate_ovf = sh[ShW-1:imu_fdb_pkg::RateW-1]
               != {(ShW-imu_fdb_pkg::RateW+1){sh[imu_fdb_pkg::RateW-1]}};
    if (s2_tag_q.smp < imu_fdb_pkg::SmpGyroX) begin
      if (acc_ovf) begin
        scaled_d = sh[ShW-1] ? imu_fdb_pkg::AccMin : imu_fdb_pkg::AccMax;
      end else begin
        scaled_d = {{(imu_fdb_pkg::RateW-imu_fdb_pkg::AccW){sh[imu_fdb_pkg::AccW-1]}},
                    sh[imu_fdb_pkg::AccW-1:0]};
      end
    end else begin
      if (rate_ovf) begin
        scaled_d = sh[ShW-1] ? imu_fdb_pkg::RateMin : imu_fdb_pkg::RateMax;
      end else begin
        scaled_d = sh[imu_fdb_pkg::RateW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (adv_i) begin
      s2_valid_q <= s1_valid_i;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod_q    <= prod_d;
      s2_tag_q  <= s1_tag_i;
      s2_addr_q <= s1_addr_i;
      scaled_q  <= scaled_d;
      bias_q    <= bias_i;
      s3_tag_q  <= s2_tag_q;
      s3_addr_q <= s2_addr_q;
    end
  end

  assign s3_valid_o  = s3_valid_q;
  assign s3_scaled_o = scaled_q;
  assign s3_bias_o   = bias_q;
  assign s3_tag_o    = s3_tag_q;
  assign s3_addr_o   = s3_addr_q;

endmodule

@@ rtl/core/imu_frame_decoder_bias.sv @@
// Result path: byte 12 of a block passes the framer, product, scaled and output registers.
// Throughput: one byte per cycle while in_stall_o is low; one 16x24 multiply per sample.
// The input stalls only while a finished result is held and a new one is ready behind it.
// Reset: registers take their defaults, the first byte is byte 0 of block 0,
// and every gyro bias entry reads as zero until captured again.
module imu_frame_decoder_bias #(
  parameter int unsigned MaxImus = imu_fdb_pkg::MaxImusDefault
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [imu_fdb_pkg::ByteW-1:0]         rx_byte_i,
  input  logic                                  frame_start_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [imu_fdb_pkg::IdxW-1:0]          imu_index_o,
  output logic signed [imu_fdb_pkg::AccW-1:0]   accel_x_o,
  output logic signed [imu_fdb_pkg::AccW-1:0]   accel_y_o,
  output logic signed [imu_fdb_pkg::AccW-1:0]   accel_z_o,
  output logic signed [imu_fdb_pkg::RateW-1:0]  rate_x_o,
  output logic signed [imu_fdb_pkg::RateW-1:0]  rate_y_o,
  output logic signed [imu_fdb_pkg::RateW-1:0]  rate_z_o,
  output logic                                  last_of_frame_o,
  input  logic                                  cfg_we_i,
  input  logic [imu_fdb_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [imu_fdb_pkg::CfgDataW-1:0]      cfg_data_i
);

  localparam int unsigned Depth = MaxImus * imu_fdb_pkg::AxesPerSensor;
  localparam int unsigned AddrW = $clog2(Depth);

  logic [imu_fdb_pkg::CountW-1:0] imu_count_q;
  logic [imu_fdb_pkg::BpiW-1:0]   bpi_q;
  logic [imu_fdb_pkg::GainW-1:0]  accel_gain_q, gyro_gain_q;
  logic                           capture_q;

  logic                           adv, accept;
  logic                           s1_valid, s3_valid;
  logic signed [imu_fdb_pkg::RawW-1:0]  s1_raw;
  imu_fdb_pkg::smp_tag_t          s1_tag, s3_tag;
  logic [AddrW-1:0]               s1_addr, s3_addr;
  logic signed [imu_fdb_pkg::RateW-1:0] s3_scaled, s3_bias, bias_eff;
  logic [imu_fdb_pkg::RateW-1:0]  bias_rd;
  logic                           bias_re, bias_we, bias_ok_q;
  logic [Depth-1:0]               bias_vld_q;
  logic [AddrW-1:0]               bias_waddr, wb_addr_q;
  logic signed [imu_fdb_pkg::RateW-1:0] bias_wdata;
  logic [1:0]                     wb_cnt_q;

  logic signed [imu_fdb_pkg::RateW:0]   diff;
  logic signed [imu_fdb_pkg::RateW-1:0] rate_sat, rate_f;
  logic signed [imu_fdb_pkg::AccW-1:0]  hold_ax_q, hold_ay_q, hold_az_q;
  logic signed [imu_fdb_pkg::RateW-1:0] hold_rx_q, hold_ry_q;
  logic                                 out_valid_q, emit;

  logic [imu_fdb_pkg::IdxW-1:0]         o_idx_q;
  logic signed [imu_fdb_pkg::AccW-1:0]  o_ax_q, o_ay_q, o_az_q;
  logic signed [imu_fdb_pkg::RateW-1:0] o_rx_q, o_ry_q, o_rz_q;
  logic                                 o_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      imu_count_q  <= imu_fdb_pkg::ImuCountRst;
      bpi_q        <= imu_fdb_pkg::BpiRst;
      accel_gain_q <= imu_fdb_pkg::AccelGainRst;
      gyro_gain_q  <= imu_fdb_pkg::GyroGainRst;
      capture_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        imu_fdb_pkg::CfgImuCount: begin
          imu_count_q <= cfg_data_i[imu_fdb_pkg::CountW-1:0];
        end
        imu_fdb_pkg::CfgBytesPerImu: begin
          bpi_q <= cfg_data_i[imu_fdb_pkg::BpiW-1:0];
        end
        imu_fdb_pkg::CfgAccelGain: begin
          accel_gain_q <= cfg_data_i[imu_fdb_pkg::GainW-1:0];
        end
        imu_fdb_pkg::CfgGyroGain: begin
          gyro_gain_q <= cfg_data_i[imu_fdb_pkg::GainW-1:0];
        end
        imu_fdb_pkg::CfgBiasCapture: begin
          capture_q <= cfg_data_i[0];
        end
        default: begin
        end
      endcase
    end
  end

  // hold the pipe only when a new result would overwrite one still waiting
  assign emit       = s3_valid && s3_tag.emit;
  assign adv        = !(emit && out_valid_q && out_stall_i);
  assign accept     = in_valid_i && adv;
  assign in_stall_o = !adv;

  imu_fdb_framer #(
    .MaxImus(MaxImus),
    .AddrW  (AddrW)
  ) u_framer (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .adv_i          (adv),
    .accept_i       (accept),
    .rx_byte_i      (rx_byte_i),
    .frame_start_i  (frame_start_i),
    .imu_count_i    (imu_count_q),
    .bytes_per_imu_i(bpi_q),
    .s1_valid_o     (s1_valid),
    .s1_raw_o       (s1_raw),
    .s1_tag_o       (s1_tag),
    .s1_addr_o      (s1_addr)
  );

  assign bias_re  = adv && s1_valid && (s1_tag.smp >= imu_fdb_pkg::SmpGyroX);
  assign bias_eff = bias_ok_q ? $signed(bias_rd) : '0;

  // commit captured bias only for a complete block: z first, then y and x
  always_comb begin
    bias_we    = 1'b0;
    bias_waddr = s3_addr;
    bias_wdata = s3_scaled;
    if (wb_cnt_q != 2'd0) begin
      bias_we    = 1'b1;
      bias_waddr = wb_addr_q;
      bias_wdata = (wb_cnt_q == 2'd2) ? hold_ry_q : hold_rx_q;
    end else if (adv && emit && capture_q) begin
      bias_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_cnt_q  <= 2'd0;
      wb_addr_q <= '0;
    end else if (wb_cnt_q != 2'd0) begin
      wb_cnt_q  <= wb_cnt_q - 2'd1;
      wb_addr_q <= wb_addr_q - AddrW'(1);
    end else if (adv && emit && capture_q) begin
      wb_cnt_q  <= 2'd2;
      wb_addr_q <= s3_addr - AddrW'(1);
    end
  end

  imu_fdb_ram #(
    .Width(imu_fdb_pkg::RateW),
    .Depth(Depth)
  ) u_bias_ram (
    .clk_i  (clk_i),
    .we_i   (bias_we),
    .waddr_i(bias_waddr),
    .wdata_i(bias_wdata),
    .re_i   (bias_re),
    .raddr_i(s1_addr),
    .rdata_o(bias_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_vld_q <= '0;
      bias_ok_q  <= 1'b0;
    end else begin
      if (bias_we) begin
        bias_vld_q[bias_waddr] <= 1'b1;
      end
      if (bias_re) begin
        bias_ok_q <= bias_vld_q[s1_addr];
      end
    end
  end

  imu_fdb_scale #(
    .AddrW(AddrW)
  ) u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .s1_valid_i  (s1_valid),
    .s1_raw_i    (s1_raw),
    .s1_tag_i    (s1_tag),
    .s1_addr_i   (s1_addr),
    .accel_gain_i(accel_gain_q),
    .gyro_gain_i (gyro_gain_q),
    .bias_i      (bias_eff),
    .s3_valid_o  (s3_valid),
    .s3_scaled_o (s3_scaled),
    .s3_bias_o   (s3_bias),
    .s3_tag_o    (s3_tag),
    .s3_addr_o   (s3_addr)
  );

  always_comb begin
    diff = {s3_scaled[imu_fdb_pkg::RateW-1], s3_scaled}
           - {s3_bias[imu_fdb_pkg::RateW-1], s3_bias};
    if (diff[imu_fdb_pkg::RateW] != diff[imu_fdb_pkg::RateW-1]) begin
      rate_sat = diff[imu_fdb_pkg::RateW] ? imu_fdb_pkg::RateMin : imu_fdb_pkg::RateMax;
    end else begin
      rate_sat = diff[imu_fdb_pkg::RateW-1:0];
    end
    rate_f = capture_q ? s3_scaled : rate_sat;
  end

  always_ff @(posedge clk_i) begin
    if (adv && s3_valid) begin
      case (s3_tag.smp)
        imu_fdb_pkg::SmpAccelX: hold_ax_q <= s3_scaled[imu_fdb_pkg::AccW-1:0];
        imu_fdb_pkg::SmpAccelY: hold_ay_q <= s3_scaled[imu_fdb_pkg::AccW-1:0];
        imu_fdb_pkg::SmpAccelZ: hold_az_q <= s3_scaled[imu_fdb_pkg::AccW-1:0];
        imu_fdb_pkg::SmpGyroX:  hold_rx_q <= rate_f;
        imu_fdb_pkg::SmpGyroY:  hold_ry_q <= rate_f;
        default: begin
        end
      endcase
    end
    if (adv && emit) begin
      o_idx_q  <= s3_tag.idx;
      o_ax_q   <= hold_ax_q;
      o_ay_q   <= hold_ay_q;
      o_az_q   <= hold_az_q;
      o_rx_q   <= hold_rx_q;
      o_ry_q   <= hold_ry_q;
      o_rz_q   <= rate_f;
      o_last_q <= s3_tag.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign imu_index_o     = o_idx_q;
  assign accel_x_o       = o_ax_q;
  assign accel_y_o       = o_ay_q;
  assign accel_z_o       = o_az_q;
  assign rate_x_o        = o_rx_q;
  assign rate_y_o        = o_ry_q;
  assign rate_z_o        = o_rz_q;
  assign last_of_frame_o = o_last_q;

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (emit && out_valid_q && out_stall_i))
    else $error("input stalled without a blocked result");

  a_emit_last_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (s3_tag.smp == imu_fdb_pkg::SmpGyroZ))
    else $error("result emitted on a sample other than gyro z");

  a_bias_write_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bias_we |-> (capture_q || (wb_cnt_q != 2'd0)))
    else $error("bias store written outside capture");

  a_bias_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bias_we |=> bias_vld_q[$past(bias_waddr)])
    else $error("captured bias entry not marked valid");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && emit) |=> out_valid_q)
    else $error("emitted result not presented");

endmodule

@@ dv/imu_sample_checker.sv @@
`timescale 1ns / 1ps
module imu_sample_checker import imu_fdb_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  logic [ByteW-1:0]         rx_byte_i,
  input  logic                     frame_start_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic [IdxW-1:0]          imu_index_i,
  input  logic signed [AccW-1:0]   accel_x_i,
  input  logic signed [AccW-1:0]   accel_y_i,
  input  logic signed [AccW-1:0]   accel_z_i,
  input  logic signed [RateW-1:0]  rate_x_i,
  input  logic signed [RateW-1:0]  rate_y_i,
  input  logic signed [RateW-1:0]  rate_z_i,
  input  logic                     last_of_frame_i,
  input  logic                     cfg_we_i,
  input  logic [CfgIdxW-1:0]       cfg_index_i,
  input  logic [CfgDataW-1:0]      cfg_data_i,
  output int                       pending_o,
  output int                       fail_count_o
);

  localparam int unsigned BiasDepth = MaxImusDefault * AxesPerSensor;

  typedef struct packed {
    logic [IdxW-1:0]         idx;
    logic signed [AccW-1:0]  ax;
    logic signed [AccW-1:0]  ay;
    logic signed [AccW-1:0]  az;
    logic signed [RateW-1:0] gx;
    logic signed [RateW-1:0] gy;
    logic signed [RateW-1:0] gz;
    logic                    last;
  } imu_sample_t;

  logic [CountW-1:0]       n_imus;
  logic [BpiW-1:0]         blk_len;
  logic [GainW-1:0]        acc_gain;
  logic [GainW-1:0]        gyr_gain;
  logic                    capture;

  int unsigned             byte_pos;
  int unsigned             blk_num;
  logic [ByteW-1:0]        hi_byte;
  logic signed [RateW-1:0] smp_hold [6];
  logic signed [RateW-1:0] gyro_bias [BiasDepth];

  imu_sample_t             expected_samples [$];
  int                      fails = 0;

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint scale_word(logic [RawW-1:0] raw, logic [GainW-1:0] gain,
                                        longint lo, longint hi);
    longint p;
    p = longint'($signed(raw)) * longint'(gain);
    return clamp(p >>> ScaleSh, lo, hi);
  endfunction

  task automatic decode_byte(logic [ByteW-1:0] b, logic fs);
    int unsigned cnt;
    int unsigned len;
    int unsigned k;
    int unsigned bi;
    longint      rate [3];
    imu_sample_t s;
    cnt = (n_imus == 0) ? 1 : ((n_imus > MaxImusDefault) ? MaxImusDefault : n_imus);
    len = (blk_len < BpiMin) ? BpiMin : ((blk_len > BpiMax) ? BpiMax : blk_len);
    if (fs) begin
      byte_pos = 0;
      blk_num = 0;
    end
    if (blk_num >= cnt) return;
    if (byte_pos >= PosFirstData && byte_pos <= PosLastData) begin
      if (byte_pos % 2 == 1) begin
        hi_byte = b;
      end else begin
        k = (byte_pos - PosFirstSample) / 2;
        if (k < SmpGyroX) begin
          smp_hold[k] = scale_word({hi_byte, b}, acc_gain, AccMin, AccMax);
        end else begin
          smp_hold[k] = scale_word({hi_byte, b}, gyr_gain, RateMin, RateMax);
        end
      end
    end
    if (byte_pos == PosLastData) begin
      for (int j = 0; j < AxesPerSensor; j++) begin
        bi = (blk_num * AxesPerSensor + j) % BiasDepth;
        if (capture) begin
          gyro_bias[bi] = smp_hold[SmpGyroX + j];
          rate[j] = smp_hold[SmpGyroX + j];
        end else begin
          rate[j] = clamp(longint'(smp_hold[SmpGyroX + j]) - longint'(gyro_bias[bi]),
                          RateMin, RateMax);
        end
      end
      s.idx  = blk_num[IdxW-1:0];
      s.ax   = smp_hold[SmpAccelX][AccW-1:0];
      s.ay   = smp_hold[SmpAccelY][AccW-1:0];
      s.az   = smp_hold[SmpAccelZ][AccW-1:0];
      s.gx   = rate[0][RateW-1:0];
      s.gy   = rate[1][RateW-1:0];
      s.gz   = rate[2][RateW-1:0];
      s.last = (blk_num + 1 == cnt);
      expected_samples.push_back(s);
    end
    byte_pos++;
    if (byte_pos >= len) begin
      byte_pos = 0;
      blk_num++;
    end
  endtask

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    imu_sample_t s;
    if (!rst_ni) begin
      n_imus   = ImuCountRst;
      blk_len  = BpiRst;
      acc_gain = AccelGainRst;
      gyr_gain = GyroGainRst;
      capture  = 1'b0;
      byte_pos = 0;
      blk_num  = 0;
      hi_byte  = '0;
      foreach (smp_hold[i]) smp_hold[i] = '0;
      foreach (gyro_bias[i]) gyro_bias[i] = '0;
      expected_samples.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgImuCount:    n_imus   = cfg_data_i[CountW-1:0];
          CfgBytesPerImu: blk_len  = cfg_data_i[BpiW-1:0];
          CfgAccelGain:   acc_gain = cfg_data_i[GainW-1:0];
          CfgGyroGain:    gyr_gain = cfg_data_i[GainW-1:0];
          CfgBiasCapture: capture  = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) decode_byte(rx_byte_i, frame_start_i);
      if (out_valid_i && !out_stall_i) begin
        if (expected_samples.size() == 0) begin
          $error("result word for imu %0d with no expectation pending", imu_index_i);
          fails++;
        end else begin
          s = expected_samples.pop_front();
          check_field("imu_index", s.idx, imu_index_i);
          check_field("accel_x", $signed(s.ax), accel_x_i);
          check_field("accel_y", $signed(s.ay), accel_y_i);
          check_field("accel_z", $signed(s.az), accel_z_i);
          check_field("rate_x", $signed(s.gx), rate_x_i);
          check_field("rate_y", $signed(s.gy), rate_y_i);
          check_field("rate_z", $signed(s.gz), rate_z_i);
          check_field("last_of_frame", s.last, last_of_frame_i);
        end
      end
    end
    pending_o    = expected_samples.size();
    fail_count_o = fails;
  end

endmodule

@@ dv/imu_frame_decoder_bias_tb.sv @@
`timescale 1ns / 1ps
module imu_frame_decoder_bias_tb;
  import imu_fdb_pkg::*;

  localparam int unsigned ItemTarget   = 1850;
  localparam int unsigned QuietLimit   = 5000;
  localparam int unsigned SettleCycles = 10;
  localparam int unsigned MaxWait      = 13;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [ByteW-1:0]        rx_byte_i;
  logic                    frame_start_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic [IdxW-1:0]         imu_index_o;
  logic signed [AccW-1:0]  accel_x_o;
  logic signed [AccW-1:0]  accel_y_o;
  logic signed [AccW-1:0]  accel_z_o;
  logic signed [RateW-1:0] rate_x_o;
  logic signed [RateW-1:0] rate_y_o;
  logic signed [RateW-1:0] rate_z_o;
  logic                    last_of_frame_o;
  logic                    cfg_we_i;
  logic [CfgIdxW-1:0]      cfg_index_i;
  logic [CfgDataW-1:0]     cfg_data_i;

  int                      pending;
  int                      fail_count;
  int unsigned             bytes_sent = 0;
  int unsigned             quiet_cycles = 0;
  int unsigned             frame_imus = 1;
  int unsigned             frame_len = 13;
  bit                      fast_phase = 1'b0;

  imu_frame_decoder_bias u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .rx_byte_i       (rx_byte_i),
    .frame_start_i   (frame_start_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .imu_index_o     (imu_index_o),
    .accel_x_o       (accel_x_o),
    .accel_y_o       (accel_y_o),
    .accel_z_o       (accel_z_o),
    .rate_x_o        (rate_x_o),
    .rate_y_o        (rate_y_o),
    .rate_z_o        (rate_z_o),
    .last_of_frame_o (last_of_frame_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  imu_sample_checker u_chk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .rx_byte_i       (rx_byte_i),
    .frame_start_i   (frame_start_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .imu_index_i     (imu_index_o),
    .accel_x_i       (accel_x_o),
    .accel_y_i       (accel_y_o),
    .accel_z_i       (accel_z_o),
    .rate_x_i        (rate_x_o),
    .rate_y_i        (rate_y_o),
    .rate_z_i        (rate_z_o),
    .last_of_frame_i (last_of_frame_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .pending_o       (pending),
    .fail_count_o    (fail_count)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // result side: stall a random number of cycles (none in the fast phase), then take one word
  initial begin
    int unsigned n;
    out_stall_i = 1'b0;
    @(negedge clk_i);
    forever begin
      n = fast_phase ? 0 : $urandom_range(0, MaxWait);
      if (n != 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  task automatic send_byte(input logic [ByteW-1:0] b, input logic fs);
    int unsigned gap;
    gap = fast_phase ? 0 : $urandom_range(0, MaxWait);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    rx_byte_i     <= b;
    frame_start_i <= fs;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_block(input logic fs, input logic [RawW-1:0] a0, a1, a2, g0, g1, g2);
    logic [RawW-1:0] w [6];
    w = '{a0, a1, a2, g0, g1, g2};
    send_byte(ByteW'($urandom), fs);
    foreach (w[i]) begin
      send_byte(w[i][15:8], 1'b0);
      send_byte(w[i][7:0], 1'b0);
    end
  endtask

  // hold the input, then wait for the decoder to drain
  task automatic settle_idle();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic reg_write(input logic [CfgIdxW-1:0] idx, input int unsigned value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CfgDataW'(value);
    @(negedge clk_i);
  endtask

  task automatic set_config(input int unsigned count, input int unsigned bpi,
                            input int unsigned ag, input int unsigned gg, input bit cap);
    reg_write(CfgImuCount, count);
    reg_write(CfgBytesPerImu, bpi);
    reg_write(CfgAccelGain, ag);
    reg_write(CfgGyroGain, gg);
    reg_write(CfgBiasCapture, 32'(cap));
    cfg_we_i <= 1'b0;
    frame_imus = (count == 0) ? 1 : ((count > MaxImusDefault) ? MaxImusDefault : count);
    frame_len  = (bpi < BpiMin) ? BpiMin : ((bpi > BpiMax) ? BpiMax : bpi);
  endtask

  function automatic logic [ByteW-1:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return ByteW'($urandom);
    endcase
  endfunction

  function automatic int unsigned pick_gain();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 32'hFFFFFF;
      2: return $urandom_range(0, 4095);
      3: return 32'(AccelGainRst);
      4: return 32'(GyroGainRst);
      default: return $urandom & 32'hFFFFFF;
    endcase
  endfunction

  // well-formed frame, sometimes cut short, trailed by extra bytes or noise
  task automatic send_frame();
    int unsigned total;
    int unsigned cut;
    total = frame_imus * frame_len;
    cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, total - 1) : total;
    for (int unsigned i = 0; i < cut; i++) send_byte(pick_byte(), i == 0);
    if (cut == total && $urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 5)) send_byte(pick_byte(), 1'b0);
    end
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6)) send_byte(pick_byte(), $urandom_range(0, 3) == 0);
    end
  endtask

  initial begin
    int unsigned count_w;
    int unsigned bpi_w;
    int unsigned n_frames;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    rx_byte_i     = '0;
    frame_start_i = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = CfgImuCount;
    cfg_data_i    = '0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // no frame start yet: the first byte is byte 0 of block 0
    send_block(1'b0, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF);
    settle_idle();
    set_config(1, 13, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
    send_block(1'b1, 16'h8000, 16'h7FFF, 16'h0001, 16'h8000, 16'h8000, 16'h8000);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    settle_idle();
    set_config(1, 13, 24'hFFFFFF, 24'hFFFFFF, 1'b0);
    send_block(1'b1, 16'h0000, 16'hFFFF, 16'h8001, 16'h7FFF, 16'h7FFF, 16'h7FFF);

    while (bytes_sent < ItemTarget) begin
      settle_idle();
      case ($urandom_range(0, 9))
        0: count_w = 0;
        1: count_w = MaxImusDefault;
        2: count_w = $urandom_range(17, 31);
        default: count_w = $urandom_range(1, 4);
      endcase
      if (count_w > 4 || count_w == 0 && $urandom_range(0, 1) == 0) begin
        bpi_w = $urandom_range(0, 1) ? $urandom_range(0, 12) : $urandom_range(13, 14);
      end else begin
        case ($urandom_range(0, 9))
          0: bpi_w = $urandom_range(0, 12);
          1: bpi_w = BpiMax;
          2: bpi_w = $urandom_range(65, 127);
          default: bpi_w = $urandom_range(13, 18);
        endcase
      end
      set_config(count_w, bpi_w, pick_gain(), pick_gain(), $urandom_range(0, 3) == 0);
      fast_phase = ($urandom_range(0, 4) == 0);
      n_frames = (frame_imus * frame_len > 200) ? 1 : $urandom_range(2, 6);
      repeat (n_frames) begin
        if (bytes_sent < ItemTarget) send_frame();
      end
    end

    settle_idle();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ imu_frame_decoder_bias.f @@
rtl/core/imu_fdb_pkg.sv
rtl/core/imu_fdb_ram.sv
rtl/core/imu_fdb_framer.sv
rtl/core/imu_fdb_scale.sv
rtl/core/imu_frame_decoder_bias.sv
dv/imu_sample_checker.sv
dv/imu_frame_decoder_bias_tb.sv
